// ----- rtl/olte_pkg.sv -----
// ----------------------------------------------------------------------------
// olte_pkg
// Shared constants, types and elaboration helpers for the time code encoder.
// ----------------------------------------------------------------------------
package olte_pkg;

	// Input duration width in milliseconds
	localparam int MS_W = 22;
	// Scaling unit C in microseconds
	localparam longint UNIT_US = 62500;
	localparam longint US_PER_MS = 1000;

	// Code layout: mantissa in the upper nibble, exponent in the lower nibble
	localparam int MANT_W = 4;
	localparam int EXPO_FLD_W = 4;
	localparam int CODE_W = MANT_W + EXPO_FLD_W;
	localparam int MANT_ONE = 2 ** MANT_W;
	localparam int EXPO_MAX = 2 ** EXPO_FLD_W - 1;

	// Binary gcd, evaluated at elaboration only
	function automatic longint gcd_f(longint x, longint y);
		longint u;
		longint v;
		longint w;
		int sh;
		u = x;
		v = y;
		sh = 0;
		for (int i = 0; i < 64; i++) begin
			if (u != 0 && v != 0 && u[0] == 1'b0 && v[0] == 1'b0) begin
				u = u >> 1;
				v = v >> 1;
				sh = sh + 1;
			end
		end
		for (int i = 0; i < 64; i++) begin
			if (u != 0 && u[0] == 1'b0) begin
				u = u >> 1;
			end
		end
		for (int i = 0; i < 256; i++) begin
			if (v != 0) begin
				for (int j = 0; j < 64; j++) begin
					if (v[0] == 1'b0) begin
						v = v >> 1;
					end
				end
				if (u > v) begin
					w = u;
					u = v;
					v = w;
				end
				v = v - u;
			end
		end
		return u << sh;
	endfunction

	// 16 * t / C = ms * 16000 / C, reduced to ms * NUMK / DEN
	localparam longint SCALE_NUM = US_PER_MS * MANT_ONE;
	localparam longint GCD_SC = gcd_f(SCALE_NUM, UNIT_US);
	localparam longint NUMK = SCALE_NUM / GCD_SC;
	localparam longint DEN = UNIT_US / GCD_SC;

	localparam longint MS_MAX = (64'd1 << MS_W) - 1;
	localparam int NUM_W = $clog2(MS_MAX * NUMK + 1);
	localparam int NUMK_W = $clog2(NUMK + 1);
	localparam int DEN_W = $clog2(DEN + 1);

	// Reciprocal of DEN scaled by 2^NUM_W; quotient estimate is low by at most one
	localparam longint RECIP = (64'd1 << NUM_W) / DEN;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = NUM_W + RECIP_W;

	// Scaled quotient q16 = floor(16 t / C), plain quotient q = q16 >> MANT_W
	localparam int Q16_W = $clog2(MS_MAX * NUMK / DEN + 1);
	localparam int Q_W = Q16_W - MANT_W;
	localparam int EXP_W = $clog2(Q_W + 1);
	localparam int M_W = MANT_W + 1;
	localparam int MI_W = MANT_W + 2;

	// Stream byte widths
	localparam int S_TDATA_W = ((MS_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((CODE_W + 7) / 8) * 8;

	typedef struct packed {
		logic [Q16_W-1:0] q16;
		logic [EXP_W-1:0] expo;
		logic [NUM_W-1:0] num;
	} olte_quo_t;

	typedef struct packed {
		logic [CODE_W-1:0] time_code;
		logic              in_range;
	} olte_res_t;

endpackage

// ----- rtl/olte_divq.sv -----
// ----------------------------------------------------------------------------
// olte_divq
// Scaled quotient and exponent: multiply-by-reciprocal division by the
// time unit, remainder correction and leading-one search, five stages.
// ----------------------------------------------------------------------------
module olte_divq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       in_valid,
	input  logic [olte_pkg::MS_W-1:0]  in_ms,
	output logic                       out_valid,
	output olte_pkg::olte_quo_t        out_quo
);
	import olte_pkg::*;

	localparam logic [NUM_W-1:0] DEN_N = NUM_W'(DEN);
	localparam logic [NUMK_W-1:0] NUMK_N = NUMK_W'(NUMK);
	localparam logic [RECIP_W-1:0] RECIP_N = RECIP_W'(RECIP);

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [NUM_W-1:0]   num_s1, num_s2, num_s3, num_s4, num_s5;
	logic [PROD_W-1:0]  prod_s2;
	logic [Q16_W-1:0]   qa_s3;
	logic [NUM_W-1:0]   qad_s3;
	logic [Q16_W-1:0]   q16_s4, q16_s5;
	logic [EXP_W-1:0]   expo_s5;
	logic [Q16_W-1:0]   qa;
	logic [NUM_W-1:0]   rem;
	logic [Q_W-1:0]     q_int;
	logic [EXP_W-1:0]   expo;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Estimate quotient from the top of the reciprocal product
	assign qa = Q16_W'(prod_s2 >> NUM_W);

	// Remainder of the estimate, below twice the divisor
	assign rem = num_s3 - qad_s3;

	// Find the highest set bit of q; zero when q is below two
	assign q_int = q16_s4[Q16_W-1:MANT_W];
	always_comb begin
		expo = '0;
		for (int i = 0; i < Q_W; i++) begin
			if (q_int[i]) begin
				expo = EXP_W'(i);
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (ce) begin
			num_s1  <= NUM_W'(in_ms) * NUM_W'(NUMK_N);
			prod_s2 <= PROD_W'(num_s1) * PROD_W'(RECIP_N);
			num_s2  <= num_s1;
			qa_s3   <= qa;
			qad_s3  <= NUM_W'(qa) * DEN_N;
			num_s3  <= num_s2;
			q16_s4  <= (rem >= DEN_N) ? qa_s3 + Q16_W'(1) : qa_s3;
			num_s4  <= num_s3;
			q16_s5  <= q16_s4;
			expo_s5 <= expo;
			num_s5  <= num_s4;
		end
	end

	assign out_valid    = valid_s5;
	assign out_quo.q16  = q16_s5;
	assign out_quo.expo = expo_s5;
	assign out_quo.num  = num_s5;

`ifndef ASSERT_OFF
	a_q16_not_high: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (NUM_W'(q16_s4) * DEN_N <= num_s4))
		else $error("olte_divq: corrected quotient too high");
	a_q16_not_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (num_s4 - NUM_W'(q16_s4) * DEN_N < DEN_N))
		else $error("olte_divq: corrected quotient too low");
`endif

endmodule

// ----- rtl/olte_code.sv -----
// ----------------------------------------------------------------------------
// olte_code
// Mantissa extraction, back-multiplication round-up check and final code
// assembly with mantissa carry and range check.
// ----------------------------------------------------------------------------
module olte_code (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ce,
	input  logic                 in_valid,
	input  olte_pkg::olte_quo_t  in_quo,
	output logic                 out_valid,
	output olte_pkg::olte_res_t  out_res
);
	import olte_pkg::*;

	localparam int DM_W = DEN_W + M_W;
	localparam logic [DM_W-1:0] DEN_DM = DM_W'(DEN);

	logic               valid_s6, valid_s7;
	logic [M_W-1:0]     m_s6, m_s7;
	logic [EXP_W-1:0]   expo_s6, expo_s7;
	logic [NUM_W-1:0]   num_s6;
	logic               inc_s7;
	logic [DM_W-1:0]    den_m;
	logic [NUM_W-1:0]   back;
	logic [MI_W-1:0]    mi;
	logic [MI_W-1:0]    mant;
	logic [EXP_W-1:0]   expo_f;
	logic               ok;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (ce) begin
			valid_s6 <= in_valid;
			valid_s7 <= valid_s6;
		end
	end

	// Back-multiply C * m * 2^b, compared against 16 t in reduced units
	assign den_m = DEN_DM * DM_W'(m_s6);
	assign back  = NUM_W'(den_m) << expo_s6;

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (ce) begin
			m_s6    <= M_W'(in_quo.q16 >> in_quo.expo);
			expo_s6 <= in_quo.expo;
			num_s6  <= in_quo.num;
			m_s7    <= m_s6;
			expo_s7 <= expo_s6;
			inc_s7  <= (back < num_s6);
		end
	end

	// Round up, carry a full mantissa into the exponent, range check
	always_comb begin
		mi = MI_W'(m_s7) + MI_W'(inc_s7);
		if (mi == MI_W'(2 * MANT_ONE)) begin
			mant   = '0;
			expo_f = expo_s7 + EXP_W'(1);
		end else begin
			mant   = mi - MI_W'(MANT_ONE);
			expo_f = expo_s7;
		end
		ok = (mi >= MI_W'(MANT_ONE)) && (expo_f <= EXP_W'(EXPO_MAX));
		out_res.in_range  = ok;
		out_res.time_code = ok ? {mant[MANT_W-1:0], expo_f[EXPO_FLD_W-1:0]} : '0;
	end

	assign out_valid = valid_s7;

endmodule

// ----- rtl/olte_skid.sv -----
// ----------------------------------------------------------------------------
// olte_skid
// Output register with a spare slot; the ready toward the pipeline is
// registered so the receiver's ready never reaches the input side.
// ----------------------------------------------------------------------------
module olte_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  olte_pkg::olte_res_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output olte_pkg::olte_res_t  out_data
);
	import olte_pkg::*;

	logic       out_valid_q;
	logic       spare_valid_q;
	olte_res_t  out_data_q;
	olte_res_t  spare_data_q;
	logic       out_free;

	assign out_free = out_ready || !out_valid_q;
	assign in_ready = !spare_valid_q;

	// Control: refill output from spare first, park a beat when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (out_free) begin
			if (spare_valid_q) begin
				spare_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			spare_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= spare_valid_q ? spare_data_q : in_data;
		end else if (in_valid && in_ready) begin
			spare_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("olte_skid: spare slot full while output empty");
	a_park_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_valid_q && !out_ready) |=> spare_valid_q)
		else $error("olte_skid: stalled beat not parked");
`endif

endmodule

// ----- rtl/olsr_time_code_encoder.sv -----
// ----------------------------------------------------------------------------
// olsr_time_code_encoder
// Duration in milliseconds to 8-bit mantissa/exponent time code.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one beat per duration, time_ms in s_tdata[21:0].
//   Output stream (m_*): one beat per input beat, in order; time_code in
//   m_tdata[7:0], in_range on m_tuser. A duration that cannot be encoded
//   (mantissa negative or exponent above 15) gives code 0, in_range 0.
//   Throughput: one beat per cycle while m_tready stays high. The work runs
//   through a seven-stage pipeline (reciprocal multiply, remainder fix,
//   leading-one search, mantissa shift, back-multiply check) into an output
//   register.
//   Stall: when m_tready is low, the output register holds its beat and a
//   spare slot takes one more; s_tready then drops (registered) and the
//   whole pipeline holds. Nothing is lost or repeated.
//   Reset: arst_n clears all valid bits; s_tready is high after reset.
// ----------------------------------------------------------------------------
module olsr_time_code_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [olte_pkg::S_TDATA_W-1:0]   s_tdata,   // [21:0] time_ms
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [olte_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] time_code
	output logic                             m_tuser    // [0] in_range
);
	import olte_pkg::*;

	logic       ce;
	logic       quo_valid;
	olte_quo_t  quo;
	logic       res_valid;
	olte_res_t  res;
	olte_res_t  out_res;

	// Hold the pipeline whenever the output side's spare slot is full
	olte_divq u_divq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_tvalid),
		.in_ms     (s_tdata[MS_W-1:0]),
		.out_valid (quo_valid),
		.out_quo   (quo)
	);

	olte_code u_code (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (quo_valid),
		.in_quo    (quo),
		.out_valid (res_valid),
		.out_res   (res)
	);

	olte_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (ce),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign s_tready = ce;
	assign m_tdata  = M_TDATA_W'(out_res.time_code);
	assign m_tuser  = out_res.in_range;

endmodule

// ----- tb/olsr_time_code_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// olsr_time_code_encoder_tb
// Stream-level check of the duration to mantissa/exponent time code encoder.
// Durations are offered on the input stream, partly in bursts. Each accepted beat is
// encoded by a predictor in the scoreboard, and every output beat is compared
// with the oldest pending code. The receiver applies its own back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olsr_time_code_encoder_tb;
	import olte_pkg::*;

	// Encodes durations the same way the block should and holds the codes in order
	class code_scoreboard;
		olte_res_t pending_codes[$];
		int n_errors;
		int n_checked;
		int n_encoded;

		function new();
			n_errors = 0;
			n_checked = 0;
			n_encoded = 0;
		endfunction

		function olte_res_t encode_ms(logic [MS_W-1:0] ms);
			logic [63:0] usec;
			logic [63:0] unit;
			logic [63:0] quo;
			logic [63:0] mant;
			logic [63:0] back;
			longint expo_v;
			longint mant_v;
			olte_res_t r;
			unit = 64'(UNIT_US);
			usec = 64'(ms) * 64'(US_PER_MS);
			quo = usec / unit;
			// highest power of two not above t/C
			expo_v = 0;
			while (expo_v < 62 && quo >= (64'd1 << (expo_v + 1)))
				expo_v++;
			mant = ((usec << MANT_W) / unit) >> expo_v;
			mant_v = longint'(mant) - MANT_ONE;
			// round the mantissa up when the back-multiplied value falls short
			back = ((unit * mant) << expo_v) >> MANT_W;
			if (back < usec)
				mant_v++;
			// carry a full mantissa into the exponent
			if (mant_v == MANT_ONE) begin
				expo_v++;
				mant_v = 0;
			end
			r.time_code = '0;
			r.in_range = 1'b0;
			if (mant_v >= 0 && mant_v <= MANT_ONE - 1 && expo_v <= EXPO_MAX) begin
				r.time_code = {mant_v[MANT_W-1:0], expo_v[EXPO_FLD_W-1:0]};
				r.in_range = 1'b1;
			end
			return r;
		endfunction

		function void note_duration(logic [MS_W-1:0] ms);
			pending_codes.insert(pending_codes.size(), encode_ms(ms));
		endfunction

		function void check_code(logic [CODE_W-1:0] code, logic ok);
			olte_res_t want;
			if (pending_codes.size() == 0) begin
				$error("output beat with no pending code: time_code=%0h in_range=%0b",
					code, ok);
				n_errors++;
				return;
			end
			want = pending_codes.pop_front();
			n_checked++;
			if (want.in_range)
				n_encoded++;
			if (code !== want.time_code) begin
				$error("time_code mismatch: expected %0h, actual %0h", want.time_code, code);
				n_errors++;
			end
			if (ok !== want.in_range) begin
				$error("in_range mismatch: expected %0b, actual %0b", want.in_range, ok);
				n_errors++;
			end
		endfunction

		function int pending();
			return pending_codes.size();
		endfunction
	endclass

	// Receiver back-pressure styles
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [21:0] time_ms
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [7:0] time_code
	logic                 m_tuser;   // [0] in_range

	code_scoreboard sb;
	rx_mode_t rx_mode;
	int hold_left;
	int n_sent;

	olsr_time_code_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Guard against a hung handshake
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: drive tready on the falling edge; a long hold-off counts down here
	initial begin
		logic [9:0] rx_pat;
		m_tready = 1'b0;
		rx_pat = 10'b1101100101;
		forever begin
			@(negedge clk);
			rx_pat = {rx_pat[8:0], rx_pat[9]};
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_OPEN:    m_tready <= 1'b1;
					RX_RANDOM:  m_tready <= ($urandom_range(0, 9) < 6);
					RX_PATTERN: m_tready <= rx_pat[0];
					default:    m_tready <= 1'b1;
				endcase
			end
		end
	end

	// Check every output beat at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_code(m_tdata[CODE_W-1:0], m_tuser);
	end

	// Offer one duration and hold it until the block takes the beat
	task automatic send_duration(logic [MS_W-1:0] ms);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(ms);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_duration(ms);
		n_sent++;
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Stop offering and wait until every pending code has come out
	task automatic drain_codes();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mix of plain random, log-spread and rounding/carry boundary durations
	function automatic logic [MS_W-1:0] pick_duration();
		logic [63:0] center;
		int k;
		int a;
		int e;
		logic [63:0] lim;
		case ($urandom_range(0, 3))
			0: return MS_W'($urandom);
			1: begin
				e = $urandom_range(1, MS_W);
				return MS_W'($urandom_range(0, (1 << e) - 1));
			end
			default: begin
				k = $urandom_range(0, EXPO_MAX + 1);
				a = $urandom_range(0, MANT_ONE);
				center = ((64'(UNIT_US) * 64'(MANT_ONE + a)) << k)
					/ (64'(US_PER_MS) * 64'(MANT_ONE));
				center = center + 64'($urandom_range(0, 4)) - 64'd2;
				lim = (64'd1 << MS_W) - 1;
				if (center > lim)
					center = lim;
				return MS_W'(center);
			end
		endcase
	endfunction

	// Random beats, optionally in bursts separated by idle gaps
	task automatic run_random(int n, bit gaps);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (gaps && burst == 0) begin
				idle_cycles($urandom_range(1, 6));
				burst = $urandom_range(1, 12);
			end
			send_duration(pick_duration());
			if (burst > 0)
				burst--;
		end
	endtask

	initial begin
		logic [MS_W-1:0] corner_ms[$];
		sb = new();
		n_sent = 0;
		hold_left = 0;
		rx_mode = RX_OPEN;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero, below one unit, unit edges, mantissa carry into the exponent,
		// edge of the largest exponent, exponent overflow and the full field width
		corner_ms = '{0, 1, 62, 63, 64, 100, 124, 125, 126, 500, 1000, 3937,
			2047999, 2048000, 2147483, 2150000, 4095999, 4096000, 4194303,
			22'h2AAAAA, 22'h155555};
		foreach (corner_ms[i])
			send_duration(corner_ms[i]);
		drain_codes();

		// long receiver hold-off while the sender keeps pushing: the block fills
		hold_left = 300;
		run_random(40, 1'b0);
		drain_codes();

		rx_mode = RX_OPEN;
		run_random(120, 1'b1);
		rx_mode = RX_RANDOM;
		run_random(120, 1'b0);
		drain_codes();
		rx_mode = RX_PATTERN;
		run_random(120, 1'b1);
		rx_mode = RX_RANDOM;
		run_random(120, 1'b1);
		drain_codes();

		repeat (20) @(posedge clk);
		$display("Sent %0d durations, checked %0d codes (%0d encodable, %0d rejected).",
			n_sent, sb.n_checked, sb.n_encoded, sb.n_checked - sb.n_encoded);
		$display("Covered corner durations, a long output hold-off, bursts and back-pressure.");
		if (sb.n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
